### rtl/core/sclp_pkg.sv
// Shared types, constants and the byte classifier for the command line parser.
package sclp_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_EOL  = 8'h00;
    localparam logic [7:0] CH_PIPE = 8'h7C;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    typedef enum logic [1:0] {
        SP_PIPE,
        SP_AMP,
        SP_LT,
        SP_GT
    } t_spec;

    typedef enum logic [2:0] {
        PH_EXPECT_CMD,
        PH_IN_CMD,
        PH_NEED_IN,
        PH_NEED_OUT,
        PH_NAME_IN,
        PH_NAME_OUT,
        PH_AFTER_REDIR,
        PH_AFTER_BG
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_IGNORED,
        ROLE_ARG,
        ROLE_STDIN_NAME,
        ROLE_STDOUT_NAME,
        ROLE_PIPE,
        ROLE_BACKGROUND,
        ROLE_REDIR_IN,
        ROLE_REDIR_OUT
    } t_role;

    typedef enum logic [3:0] {
        ST_OK,
        ST_OK_BG,
        ST_EMPTY,
        ST_AFTER_BG,
        ST_DUP_IN,
        ST_DUP_OUT,
        ST_BAD_NAME,
        ST_NO_NAME,
        ST_WORD_REDIR
    } t_status;

    typedef struct packed {
        logic  eol;
        logic  blank;
        logic  special;
        t_spec kind;
        logic  name_ok;
    } t_cls;

    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
    } t_item;

    function automatic t_cls classify(input logic [7:0] ch);
        t_cls c;
        c.eol     = (ch == CH_EOL);
        c.blank   = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
        c.special = (ch == CH_PIPE) || (ch == CH_AMP) || (ch == CH_LT) || (ch == CH_GT);
        if (ch == CH_PIPE) begin
            c.kind = SP_PIPE;
        end else if (ch == CH_AMP) begin
            c.kind = SP_AMP;
        end else if (ch == CH_LT) begin
            c.kind = SP_LT;
        end else begin
            c.kind = SP_GT;
        end
        c.name_ok = ((ch >= 8'h30) && (ch <= 8'h39)) || ((ch >= 8'h61) && (ch <= 8'h7A))
                 || ((ch >= 8'h41) && (ch <= 8'h5A)) || (ch == 8'h5F) || (ch == 8'h2D)
                 || (ch == 8'h2E) || (ch == 8'h2C) || (ch == 8'h2F) || (ch == 8'h7E)
                 || (ch == 8'h2B);
        return c;
    endfunction

endpackage

### rtl/core/sclp_front.sv
// Front end: accepts input bytes, classifies them and hands them to the queue.
module sclp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_ch,
    output logic                o_stall,
    input  logic                i_q_full,
    output logic                o_push,
    output sclp_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    sclp_pkg::t_item r_item;
    logic            accept;

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.ch  <= i_ch;
            r_item.cls <= sclp_pkg::classify(i_ch);
        end
    end

endmodule

### rtl/core/sclp_queue.sv
// Short queue of classified bytes between the front end and the back end.
module sclp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sclp_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_not_empty,
    output sclp_pkg::t_item o_item
);

    sclp_pkg::t_item                 r_mem [sclp_pkg::QDEPTH];
    logic [sclp_pkg::QPTR_W-1:0]     r_wptr;
    logic [sclp_pkg::QPTR_W-1:0]     r_rptr;
    logic [sclp_pkg::QCNT_W-1:0]     r_count;
    logic [sclp_pkg::QPTR_W-1:0]     n_wptr;
    logic [sclp_pkg::QPTR_W-1:0]     n_rptr;
    logic [sclp_pkg::QCNT_W-1:0]     n_count;

    localparam logic [sclp_pkg::QPTR_W-1:0] PTR_LAST = sclp_pkg::QPTR_W'(sclp_pkg::QDEPTH - 1);
    localparam logic [sclp_pkg::QCNT_W-1:0] CNT_FULL = sclp_pkg::QCNT_W'(sclp_pkg::QDEPTH);

    assign o_full      = (r_count == CNT_FULL);
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

### rtl/core/sclp_back.sv
// Back end: parser state machine and the registered result stage.
module sclp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_not_empty,
    input  sclp_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_byte_out,
    output logic [2:0]      o_role,
    output logic            o_token_start,
    output logic            o_new_command,
    output logic            o_line_done,
    output logic [3:0]      o_status
);

    sclp_pkg::t_phase  r_phase, n_phase;
    logic              r_inside, n_inside;
    logic              r_in_taken, n_in_taken;
    logic              r_out_taken, n_out_taken;
    sclp_pkg::t_status r_err, n_err;

    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_byte;
    sclp_pkg::t_role   r_role, role;
    logic              r_tstart, tstart;
    logic              r_newcmd, newcmd;
    logic              r_done, done;
    sclp_pkg::t_status r_status, status;

    // Outcome of a special token that follows a complete program or filename.
    sclp_pkg::t_status sp_err;
    sclp_pkg::t_phase  sp_phase;
    sclp_pkg::t_role   sp_role;
    sclp_pkg::t_status err;
    sclp_pkg::t_cls    cls;

    assign o_pop   = i_q_not_empty && (!r_ovalid || !i_stall);
    assign cls     = i_item.cls;

    always_comb begin
        sp_err   = sclp_pkg::ST_OK;
        sp_phase = r_phase;
        sp_role  = sclp_pkg::ROLE_IGNORED;
        case (cls.kind)
            sclp_pkg::SP_PIPE: begin
                sp_phase = sclp_pkg::PH_EXPECT_CMD;
                sp_role  = sclp_pkg::ROLE_PIPE;
            end
            sclp_pkg::SP_AMP: begin
                sp_phase = sclp_pkg::PH_AFTER_BG;
                sp_role  = sclp_pkg::ROLE_BACKGROUND;
            end
            sclp_pkg::SP_LT: begin
                if (r_in_taken) begin
                    sp_err = sclp_pkg::ST_DUP_IN;
                end
                sp_phase = sclp_pkg::PH_NEED_IN;
                sp_role  = sclp_pkg::ROLE_REDIR_IN;
            end
            default: begin
                if (r_out_taken) begin
                    sp_err = sclp_pkg::ST_DUP_OUT;
                end
                sp_phase = sclp_pkg::PH_NEED_OUT;
                sp_role  = sclp_pkg::ROLE_REDIR_OUT;
            end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_inside    = r_inside;
        n_in_taken  = r_in_taken;
        n_out_taken = r_out_taken;
        n_err       = r_err;
        role        = sclp_pkg::ROLE_IGNORED;
        tstart      = 1'b0;
        newcmd      = 1'b0;
        done        = 1'b0;
        status      = sclp_pkg::ST_OK;
        err         = sclp_pkg::ST_OK;

        if (cls.eol) begin
            done = 1'b1;
            if (r_err != sclp_pkg::ST_OK) begin
                status = r_err;
            end else if (r_phase == sclp_pkg::PH_EXPECT_CMD) begin
                status = sclp_pkg::ST_EMPTY;
            end else if (r_phase == sclp_pkg::PH_NEED_IN || r_phase == sclp_pkg::PH_NEED_OUT) begin
                status = sclp_pkg::ST_NO_NAME;
            end else if (r_phase == sclp_pkg::PH_AFTER_BG) begin
                status = sclp_pkg::ST_OK_BG;
            end
            n_phase     = sclp_pkg::PH_EXPECT_CMD;
            n_inside    = 1'b0;
            n_in_taken  = 1'b0;
            n_out_taken = 1'b0;
            n_err       = sclp_pkg::ST_OK;
        end else if (r_err == sclp_pkg::ST_OK) begin
            unique case (r_phase)
                sclp_pkg::PH_EXPECT_CMD: begin
                    if (cls.special) begin
                        err = sclp_pkg::ST_EMPTY;
                    end else if (!cls.blank) begin
                        role     = sclp_pkg::ROLE_ARG;
                        tstart   = 1'b1;
                        newcmd   = 1'b1;
                        n_inside = 1'b1;
                        n_phase  = sclp_pkg::PH_IN_CMD;
                    end
                end
                sclp_pkg::PH_IN_CMD: begin
                    if (cls.blank) begin
                        n_inside = 1'b0;
                    end else if (cls.special) begin
                        n_inside = 1'b0;
                        err      = sp_err;
                    end else begin
                        role     = sclp_pkg::ROLE_ARG;
                        tstart   = !r_inside;
                        n_inside = 1'b1;
                    end
                end
                sclp_pkg::PH_NEED_IN, sclp_pkg::PH_NEED_OUT: begin
                    if (!cls.blank) begin
                        if (cls.special || !cls.name_ok) begin
                            err = sclp_pkg::ST_BAD_NAME;
                        end else begin
                            tstart   = 1'b1;
                            n_inside = 1'b1;
                            if (r_phase == sclp_pkg::PH_NEED_IN) begin
                                role    = sclp_pkg::ROLE_STDIN_NAME;
                                n_phase = sclp_pkg::PH_NAME_IN;
                            end else begin
                                role    = sclp_pkg::ROLE_STDOUT_NAME;
                                n_phase = sclp_pkg::PH_NAME_OUT;
                            end
                        end
                    end
                end
                sclp_pkg::PH_NAME_IN, sclp_pkg::PH_NAME_OUT: begin
                    if (cls.blank) begin
                        n_inside = 1'b0;
                        n_phase  = sclp_pkg::PH_AFTER_REDIR;
                    end else if (cls.special) begin
                        n_inside = 1'b0;
                        err      = sp_err;
                    end else if (!cls.name_ok) begin
                        err = sclp_pkg::ST_BAD_NAME;
                    end else begin
                        role = (r_phase == sclp_pkg::PH_NAME_IN) ? sclp_pkg::ROLE_STDIN_NAME
                                                                 : sclp_pkg::ROLE_STDOUT_NAME;
                    end
                end
                sclp_pkg::PH_AFTER_REDIR: begin
                    if (cls.special) begin
                        n_inside = 1'b0;
                        err      = sp_err;
                    end else if (!cls.blank) begin
                        err = sclp_pkg::ST_WORD_REDIR;
                    end
                end
                sclp_pkg::PH_AFTER_BG: begin
                    if (!cls.blank) begin
                        err = sclp_pkg::ST_AFTER_BG;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            // A special token that was taken cleanly moves the phase on.
            if (cls.special && !cls.blank && err == sclp_pkg::ST_OK
                    && r_phase != sclp_pkg::PH_EXPECT_CMD
                    && r_phase != sclp_pkg::PH_NEED_IN
                    && r_phase != sclp_pkg::PH_NEED_OUT
                    && r_phase != sclp_pkg::PH_AFTER_BG) begin
                n_phase = sp_phase;
                role    = sp_role;
                tstart  = 1'b1;
                if (cls.kind == sclp_pkg::SP_LT) begin
                    n_in_taken = 1'b1;
                end
                if (cls.kind == sclp_pkg::SP_GT) begin
                    n_out_taken = 1'b1;
                end
            end

            if (err != sclp_pkg::ST_OK) begin
                n_err    = err;
                n_inside = 1'b0;
                role     = sclp_pkg::ROLE_IGNORED;
                tstart   = 1'b0;
                newcmd   = 1'b0;
            end
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_pop) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sclp_pkg::PH_EXPECT_CMD;
            r_inside    <= 1'b0;
            r_in_taken  <= 1'b0;
            r_out_taken <= 1'b0;
            r_err       <= sclp_pkg::ST_OK;
            r_ovalid    <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (o_pop) begin
                r_phase     <= n_phase;
                r_inside    <= n_inside;
                r_in_taken  <= n_in_taken;
                r_out_taken <= n_out_taken;
                r_err       <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte   <= i_item.ch;
            r_role   <= role;
            r_tstart <= tstart;
            r_newcmd <= newcmd;
            r_done   <= done;
            r_status <= status;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_byte_out    = r_byte;
    assign o_role        = r_role;
    assign o_token_start = r_tstart;
    assign o_new_command = r_newcmd;
    assign o_line_done   = r_done;
    assign o_status      = r_status;

endmodule

### rtl/core/shell_command_line_parser.sv
// Top level of the shell command line parser: front end, queue and back end.
// Each byte passes the front end register, the queue and the result register.
// Throughput: one byte per cycle while the queue is not full.
// The four-entry queue lets the input keep flowing while the output is stalled
// until it fills. Reset (synchronous, active low) empties the queue and returns
// the parser to the start of a line with no error latched.
module shell_command_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_role,
    output logic       o_token_start,
    output logic       o_new_command,
    output logic       o_line_done,
    output logic [3:0] o_status
);

    logic            q_full;
    logic            q_not_empty;
    logic            push;
    logic            pop;
    sclp_pkg::t_item front_item;
    sclp_pkg::t_item back_item;

    sclp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_ch     (i_ch),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    sclp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_item      (back_item)
    );

    sclp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_item        (back_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_byte_out    (o_byte_out),
        .o_role        (o_role),
        .o_token_start (o_token_start),
        .o_new_command (o_new_command),
        .o_line_done   (o_line_done),
        .o_status      (o_status)
    );

endmodule
